@@ rtl/core/bnc_pkg.sv @@
// Shared types and constants of the bracket nesting checker.
// No dependencies; bnc_stack and bracket_nesting_checker refer to it by scoped names.
package bnc_pkg;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_UNMATCHED    = 4'd1,
        ST_EOF_COMMENT  = 4'd2,
        ST_EOF_LITERAL  = 4'd3,
        ST_OPEN_PAREN   = 4'd4,
        ST_OPEN_BRACKET = 4'd5,
        ST_OPEN_BRACE   = 4'd6,
        ST_OVERFLOW     = 4'd7,
        ST_HALTED       = 4'd8
    } t_status;

    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       in_string;
        logic       in_char_literal;
        logic       in_comment;
        logic       in_multiline_comment;
        logic       next_is_eof;
    } t_in_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_op;

    typedef struct packed {
        logic empty;
        logic full;
        logic next_nonempty;
    } t_stack_stat;

endpackage

@@ rtl/core/bnc_in_if.sv @@
// Input channel of the bracket nesting checker: one source byte and its lexer flags.
// Depends on nothing.
interface bnc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       in_string;
    logic       in_char_literal;
    logic       in_comment;
    logic       in_multiline_comment;
    logic       next_is_eof;

    modport source (
        output valid, char_byte, in_string, in_char_literal, in_comment,
               in_multiline_comment, next_is_eof,
        input  ready
    );
    modport sink (
        input  valid, char_byte, in_string, in_char_literal, in_comment,
               in_multiline_comment, next_is_eof,
        output ready
    );
endinterface

@@ rtl/core/bnc_out_if.sv @@
// Result channel of the bracket nesting checker: status and positions.
// Depends on nothing; widths follow the line and column parameters.
interface bnc_out_if #(
    parameter int LINE_WIDTH   = 24,
    parameter int COLUMN_WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic [3:0]              status;
    logic [LINE_WIDTH-1:0]   line_number;
    logic [COLUMN_WIDTH-1:0] column_number;
    logic [LINE_WIDTH-1:0]   open_line;
    logic [COLUMN_WIDTH-1:0] open_column;

    modport source (
        output valid, status, line_number, column_number, open_line, open_column,
        input  ready
    );
    modport sink (
        input  valid, status, line_number, column_number, open_line, open_column,
        output ready
    );
endinterface

@@ rtl/core/bnc_stack.sv @@
// Position stack for one kind of bracket: top entry in a register, the rest in a memory.
// Depends on bnc_pkg for the operation and status structs.
module bnc_stack #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bnc_pkg::t_stack_op   i_op,
    input  logic [WIDTH-1:0]     i_pos,
    output logic [WIDTH-1:0]     o_next_top,
    output bnc_pkg::t_stack_stat o_stat
);

    localparam int DW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DW-1:0]    r_depth, n_depth;
    logic [WIDTH-1:0] r_top;
    logic [WIDTH-1:0] r_mem_q;
    logic [WIDTH-1:0] r_byp;
    logic             r_use_byp;
    logic [WIDTH-1:0] below;
    logic [DW-1:0]    wr_full;
    logic [DW-1:0]    rd_full;

    // The entry under the top is read ahead into a register; after a push it is the old top.
    assign below   = r_use_byp ? r_byp : r_mem_q;
    assign wr_full = r_depth - DW'(1);
    assign rd_full = r_depth - (i_op.pop ? DW'(3) : DW'(2));

    always_comb begin
        n_depth = r_depth;
        if (i_op.push) begin
            n_depth = r_depth + DW'(1);
        end else if (i_op.pop) begin
            n_depth = r_depth - DW'(1);
        end
    end

    always_comb begin
        o_next_top = r_top;
        if (i_op.push) begin
            o_next_top = i_pos;
        end else if (i_op.pop) begin
            o_next_top = below;
        end
    end

    assign o_stat.empty         = (r_depth == '0);
    assign o_stat.full          = (r_depth == DW'(DEPTH));
    assign o_stat.next_nonempty = (n_depth != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= o_next_top;
        r_byp     <= r_top;
        r_use_byp <= i_op.push;
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push && (r_depth != '0)) begin
            mem[wr_full[AW-1:0]] <= r_top;
        end
        r_mem_q <= mem[rd_full[AW-1:0]];
    end

    a_op_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_op.push && i_op.pop))
        else $error("stack push and pop in the same cycle");

    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.push |=> r_depth == $past(r_depth) + DW'(1))
        else $error("stack depth did not grow on push");

    a_pop_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.pop |-> r_depth != '0)
        else $error("stack popped while empty");

endmodule

@@ rtl/core/bracket_nesting_checker.sv @@
// Bracket nesting checker: takes one source byte per cycle unless the result channel stalls,
// and gives one result item per byte via the input register, then the result register. The
// rate is one item every cycle while not stalled, set by the update of the line, column and
// stack-depth registers; the three position stacks sit in memories with the top entry held in
// a register and the entry below it read ahead. Stack contents need no clearing after reset.
// Once any error is reported, every later item returns the halted status until reset.
module bracket_nesting_checker #(
    parameter int STACK_DEPTH  = 64,
    parameter int LINE_WIDTH   = 24,
    parameter int COLUMN_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bnc_in_if.sink   i_in,
    bnc_out_if.source o_out
);

    localparam int PW = LINE_WIDTH + COLUMN_WIDTH;

    logic                    r_in_valid;
    bnc_pkg::t_in_item       r_in;
    logic                    advance;

    logic [LINE_WIDTH-1:0]   r_line, n_line;
    logic [COLUMN_WIDTH-1:0] r_col, n_col;
    logic                    r_halted;

    logic                    r_out_valid;
    bnc_pkg::t_status        r_out_status, n_status;
    logic [LINE_WIDTH-1:0]   r_out_line, n_out_line;
    logic [COLUMN_WIDTH-1:0] r_out_col, n_out_col;
    logic [LINE_WIDTH-1:0]   r_out_oline, n_oline;
    logic [COLUMN_WIDTH-1:0] r_out_ocol, n_ocol;

    bnc_pkg::t_stack_op      op_p, op_k, op_b;
    bnc_pkg::t_stack_stat    st_p, st_k, st_b;
    logic [PW-1:0]           top_p, top_k, top_b;
    logic [PW-1:0]           pos;

    logic scope, open_p, open_k, open_b, close_p, close_k, close_b, under, over;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.char_byte            <= i_in.char_byte;
            r_in.in_string            <= i_in.in_string;
            r_in.in_char_literal      <= i_in.in_char_literal;
            r_in.in_comment           <= i_in.in_comment;
            r_in.in_multiline_comment <= i_in.in_multiline_comment;
            r_in.next_is_eof          <= i_in.next_is_eof;
        end
    end

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (r_in.char_byte == bnc_pkg::CH_NEWLINE) begin
            if (r_line != '1) begin
                n_line = r_line + LINE_WIDTH'(1);
            end
            n_col = COLUMN_WIDTH'(1);
        end else if (r_col != '1) begin
            n_col = r_col + COLUMN_WIDTH'(1);
        end
    end

    assign pos   = {n_line, n_col};
    assign scope = !r_in.in_string && !r_in.in_char_literal && !r_in.in_comment;

    assign open_p  = scope && (r_in.char_byte == bnc_pkg::CH_LPAREN);
    assign open_k  = scope && (r_in.char_byte == bnc_pkg::CH_LBRACKET);
    assign open_b  = scope && (r_in.char_byte == bnc_pkg::CH_LBRACE);
    assign close_p = scope && (r_in.char_byte == bnc_pkg::CH_RPAREN);
    assign close_k = scope && (r_in.char_byte == bnc_pkg::CH_RBRACKET);
    assign close_b = scope && (r_in.char_byte == bnc_pkg::CH_RBRACE);

    assign under = (close_p && st_p.empty) || (close_k && st_k.empty)
                || (close_b && st_b.empty);
    assign over  = (open_p && st_p.full) || (open_k && st_k.full)
                || (open_b && st_b.full);

    always_comb begin
        op_p.push = advance && !r_halted && open_p && !st_p.full;
        op_p.pop  = advance && !r_halted && close_p && !st_p.empty;
        op_k.push = advance && !r_halted && open_k && !st_k.full;
        op_k.pop  = advance && !r_halted && close_k && !st_k.empty;
        op_b.push = advance && !r_halted && open_b && !st_b.full;
        op_b.pop  = advance && !r_halted && close_b && !st_b.empty;
    end

    always_comb begin
        n_status   = bnc_pkg::ST_OK;
        n_out_line = n_line;
        n_out_col  = n_col;
        n_oline    = '0;
        n_ocol     = '0;
        if (r_halted) begin
            n_status   = bnc_pkg::ST_HALTED;
            n_out_line = r_line;
            n_out_col  = r_col;
        end else if (under) begin
            n_status = bnc_pkg::ST_UNMATCHED;
        end else if (over) begin
            n_status = bnc_pkg::ST_OVERFLOW;
        end else if (r_in.next_is_eof) begin
            if (r_in.in_multiline_comment) begin
                n_status = bnc_pkg::ST_EOF_COMMENT;
            end else if (r_in.in_string || r_in.in_char_literal) begin
                n_status = bnc_pkg::ST_EOF_LITERAL;
            end else if (st_p.next_nonempty) begin
                n_status = bnc_pkg::ST_OPEN_PAREN;
                {n_oline, n_ocol} = top_p;
            end else if (st_k.next_nonempty) begin
                n_status = bnc_pkg::ST_OPEN_BRACKET;
                {n_oline, n_ocol} = top_k;
            end else if (st_b.next_nonempty) begin
                n_status = bnc_pkg::ST_OPEN_BRACE;
                {n_oline, n_ocol} = top_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= LINE_WIDTH'(1);
            r_col    <= '0;
            r_halted <= 1'b0;
        end else if (advance && !r_halted) begin
            r_line   <= n_line;
            r_col    <= n_col;
            r_halted <= (n_status != bnc_pkg::ST_OK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= n_status;
            r_out_line   <= n_out_line;
            r_out_col    <= n_out_col;
            r_out_oline  <= n_oline;
            r_out_ocol   <= n_ocol;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.line_number   = r_out_line;
    assign o_out.column_number = r_out_col;
    assign o_out.open_line     = r_out_oline;
    assign o_out.open_column   = r_out_ocol;

    bnc_stack #(.DEPTH(STACK_DEPTH), .WIDTH(PW)) u_paren (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op_p),
        .i_pos      (pos),
        .o_next_top (top_p),
        .o_stat     (st_p)
    );

    bnc_stack #(.DEPTH(STACK_DEPTH), .WIDTH(PW)) u_bracket (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op_k),
        .i_pos      (pos),
        .o_next_top (top_k),
        .o_stat     (st_k)
    );

    bnc_stack #(.DEPTH(STACK_DEPTH), .WIDTH(PW)) u_brace (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op_b),
        .i_pos      (pos),
        .o_next_top (top_b),
        .o_stat     (st_b)
    );

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    a_halted_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_halted) |=> (r_out_status == bnc_pkg::ST_HALTED))
        else $error("item after an error not reported as halted");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("buffered input item lost while stalled");

endmodule
